// File: src/bitmap_page_allocator_macros.svh
// Assertion helpers for the page allocator.
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define BPA_CHECK_NOW(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("bpa check failed");

// Condition must hold in the cycle after the trigger.
`define BPA_CHECK_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("bpa check failed");

`endif

// File: src/bpa_pkg.sv
package bpa_pkg;

    // Field widths
    localparam int MODE_W      = 1;
    localparam int BYTE_ADDR_W = 32;
    localparam int STATUS_W    = 2;
    localparam int ADDR_W      = 27;
    localparam int FREE_W      = 16;
    localparam int SIZE_W      = 22;
    localparam int RSV_W       = 16;
    localparam int CFG_INDEX_W = 2;

    // kilobytes per page count: size_kb / 4
    localparam int KB_SHIFT = 2;

    localparam logic [SIZE_W-1:0] RST_MEM_SIZE_KB = 22'd131072;
    localparam logic [RSV_W-1:0]  RST_RESERVED    = 16'd256;

    localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_ALLOC   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OOM     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FREED   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_MEM_SIZE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESERVED = 2'd1;

endpackage

// File: src/bpa_map_ram.sv
// Used map storage: one write port, one read port, registered read data.
module bpa_map_ram #(
    parameter int WORDS  = 1024,
    parameter int AW     = 10,
    parameter int DW     = 32
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [WORDS];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/bpa_init_word.sv
// Map word contents after a rebuild: used below used_count and at/above page_total.
module bpa_init_word #(
    parameter int WORD_BITS = 32,
    parameter int BIT_W     = 5,
    parameter int WORD_AW   = 10,
    parameter int CNT_W     = 16
) (
    input  logic [WORD_AW-1:0]   word_addr,
    input  logic [CNT_W-1:0]     used_count,
    input  logic [CNT_W-1:0]     page_total,
    output logic [WORD_BITS-1:0] word
);

    localparam int EXT_W = WORD_AW + BIT_W + 1;

    logic [EXT_W-1:0]     base;
    logic [EXT_W-1:0]     used_ext;
    logic [EXT_W-1:0]     total_ext;
    logic [EXT_W-1:0]     used_diff;
    logic [EXT_W-1:0]     total_diff;
    logic [BIT_W:0]       used_cnt;
    logic [BIT_W:0]       total_cnt;
    logic [WORD_BITS:0]   used_mask;
    logic [WORD_BITS:0]   total_mask;

    assign base      = {1'b0, word_addr, {BIT_W{1'b0}}};
    assign used_ext  = EXT_W'(used_count);
    assign total_ext = EXT_W'(page_total);
    assign used_diff  = used_ext - base;
    assign total_diff = total_ext - base;

    always_comb
    begin
        if (used_ext <= base)
        begin
            used_cnt = '0;
        end
        else if (used_diff >= EXT_W'(WORD_BITS))
        begin
            used_cnt = (BIT_W+1)'(WORD_BITS);
        end
        else
        begin
            used_cnt = used_diff[BIT_W:0];
        end

        if (total_ext <= base)
        begin
            total_cnt = '0;
        end
        else if (total_diff >= EXT_W'(WORD_BITS))
        begin
            total_cnt = (BIT_W+1)'(WORD_BITS);
        end
        else
        begin
            total_cnt = total_diff[BIT_W:0];
        end
    end

    assign used_mask  = ({{WORD_BITS{1'b0}}, 1'b1} << used_cnt) - 1'b1;
    assign total_mask = ({{WORD_BITS{1'b0}}, 1'b1} << total_cnt) - 1'b1;
    assign word = used_mask[WORD_BITS-1:0] | ~total_mask[WORD_BITS-1:0];

endmodule

// File: src/bpa_find_zero.sv
// Lowest clear bit of a map word.
module bpa_find_zero #(
    parameter int WORD_BITS = 32,
    parameter int BIT_W     = 5
) (
    input  logic [WORD_BITS-1:0] word,
    output logic                 found,
    output logic [BIT_W-1:0]     idx
);

    logic [WORD_BITS-1:0] clear_bits;

    assign clear_bits = ~word;
    assign found = |clear_bits;

    always_comb
    begin
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (clear_bits[i])
            begin
                idx = BIT_W'(i);
            end
        end
    end

endmodule

// File: src/bitmap_page_allocator.sv
// Channel   Handshake                     Payload
// request   start & !busy                 mode, byte_address
// result    done (one-cycle strobe)       status, page_address, free_pages
// config    cfg_valid & cfg_ready         cfg_index, cfg_data
//
// Allocate: map words are scanned from word 0 up (one word per cycle out of the
// map RAM read port) until a clear bit or the last word below the total is hit.
// Free: one RAM read, then one write back; done is registered after the write.
// Out-of-range free or allocate with zero pages: done on the next cycle.
// After reset and after every memory_size_kb write the map is rebuilt by a
// sweep over all MAP_WORDS map words (1024 by default) with busy high; config is
// always ready. Results cannot be stalled: done lasts exactly one cycle.
module bitmap_page_allocator #(
    parameter int PAGE_CAPACITY = 32768,
    parameter int PAGE_BYTES    = 4096,
    parameter int MAP_WORD_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // request
    input  logic                               start,
    output logic                               busy,
    input  logic [bpa_pkg::MODE_W-1:0]         mode,
    input  logic [bpa_pkg::BYTE_ADDR_W-1:0]    byte_address,
    // result
    output logic                               done,
    output logic [bpa_pkg::STATUS_W-1:0]       status,
    output logic [bpa_pkg::ADDR_W-1:0]         page_address,
    output logic [bpa_pkg::FREE_W-1:0]         free_pages,
    // config
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bpa_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bpa_pkg::SIZE_W-1:0]         cfg_data
);

    localparam int MAP_WORDS = (PAGE_CAPACITY + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(MAP_WORD_BITS);
    localparam int PIDX_W    = WORD_AW + BIT_W;
    localparam int CNT_W     = $clog2(PAGE_CAPACITY + 1);
    localparam int PB_W      = $clog2(PAGE_BYTES);
    localparam int FULL_W    = PIDX_W + PB_W;

    localparam int RST_SHIFTED = int'(bpa_pkg::RST_MEM_SIZE_KB) >> bpa_pkg::KB_SHIFT;
    localparam int RST_TOTAL   = (RST_SHIFTED > PAGE_CAPACITY) ? PAGE_CAPACITY : RST_SHIFTED;
    localparam int RST_USED    = (int'(bpa_pkg::RST_RESERVED) < RST_TOTAL) ?
                                 int'(bpa_pkg::RST_RESERVED) : RST_TOTAL;

    localparam logic [WORD_AW-1:0] SWEEP_LAST = WORD_AW'(MAP_WORDS - 1);

    // controller states
    localparam logic [1:0] ST_INIT     = 2'd0;
    localparam logic [1:0] ST_IDLE     = 2'd1;
    localparam logic [1:0] ST_SCAN     = 2'd2;
    localparam logic [1:0] ST_FREE_CHK = 2'd3;

    logic [1:0]                         state_reg, state_next;
    logic [WORD_AW-1:0]                 sweep_reg, sweep_next;
    logic [WORD_AW-1:0]                 scan_reg, scan_next;
    logic [WORD_AW-1:0]                 fword_reg, fword_next;
    logic [BIT_W-1:0]                   fbit_reg, fbit_next;
    logic [CNT_W-1:0]                   used_count_reg, used_count_next;
    logic [CNT_W-1:0]                   page_total_reg, page_total_next;
    logic [bpa_pkg::SIZE_W-1:0]         mem_size_reg, mem_size_next;
    logic [bpa_pkg::RSV_W-1:0]          reserved_reg, reserved_next;
    logic                               done_reg, done_next;
    logic [bpa_pkg::STATUS_W-1:0]       status_reg, status_next;
    logic [bpa_pkg::ADDR_W-1:0]         page_address_reg, page_address_next;
    logic [bpa_pkg::FREE_W-1:0]         free_pages_reg, free_pages_next;

    logic                               accept;
    logic                               cfg_wr;
    logic                               in_work;

    // map RAM ports
    logic                               wr_en;
    logic [WORD_AW-1:0]                 wr_addr;
    logic [MAP_WORD_BITS-1:0]           wr_data;
    logic                               rd_en;
    logic [WORD_AW-1:0]                 rd_addr;
    logic [MAP_WORD_BITS-1:0]           rd_data;

    logic [MAP_WORD_BITS-1:0]           init_word;
    logic                               zero_found;
    logic [BIT_W-1:0]                   zero_idx;
    logic [MAP_WORD_BITS-1:0]           zero_onehot;
    logic [MAP_WORD_BITS-1:0]           fbit_onehot;

    logic [CNT_W-1:0]                   total_m1;
    logic [WORD_AW-1:0]                 last_word;

    // free request decode
    logic [bpa_pkg::BYTE_ADDR_W-1:0]    free_page;
    logic                               free_in_range;
    logic [PIDX_W-1:0]                  free_pidx;

    // allocated address
    logic [PIDX_W-1:0]                  hit_pidx;
    logic [FULL_W-1:0]                  hit_full;
    logic [FULL_W+bpa_pkg::ADDR_W-1:0]  hit_ext;

    // new geometry on a memory size write
    logic [bpa_pkg::SIZE_W-1:0]         size_pages;
    logic [CNT_W-1:0]                   cfg_total;
    logic [CNT_W-1:0]                   cfg_used;

    bpa_map_ram #(
        .WORDS (MAP_WORDS),
        .AW    (WORD_AW),
        .DW    (MAP_WORD_BITS)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bpa_init_word #(
        .WORD_BITS (MAP_WORD_BITS),
        .BIT_W     (BIT_W),
        .WORD_AW   (WORD_AW),
        .CNT_W     (CNT_W)
    ) u_init (
        .word_addr  (sweep_reg),
        .used_count (used_count_reg),
        .page_total (page_total_reg),
        .word       (init_word)
    );

    bpa_find_zero #(
        .WORD_BITS (MAP_WORD_BITS),
        .BIT_W     (BIT_W)
    ) u_find (
        .word  (rd_data),
        .found (zero_found),
        .idx   (zero_idx)
    );

    assign accept    = start && !busy;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != ST_IDLE);
    assign in_work   = (state_reg == ST_SCAN) || (state_reg == ST_FREE_CHK);

    assign zero_onehot = {{(MAP_WORD_BITS-1){1'b0}}, 1'b1} << zero_idx;
    assign fbit_onehot = {{(MAP_WORD_BITS-1){1'b0}}, 1'b1} << fbit_reg;

    // last map word that can hold a page below the total
    assign total_m1  = page_total_reg - CNT_W'(1);
    assign last_word = WORD_AW'(total_m1 >> BIT_W);

    assign free_page     = byte_address >> PB_W;
    assign free_in_range = free_page < bpa_pkg::BYTE_ADDR_W'(page_total_reg);
    assign free_pidx     = free_page[PIDX_W-1:0];

    assign hit_pidx = {scan_reg, zero_idx};
    assign hit_full = {hit_pidx, {PB_W{1'b0}}};
    assign hit_ext  = {{bpa_pkg::ADDR_W{1'b0}}, hit_full};

    // size_kb / 4, saturated at capacity; used clamps to that total
    assign size_pages = cfg_data >> bpa_pkg::KB_SHIFT;
    assign cfg_total  = (32'(size_pages) > 32'(PAGE_CAPACITY)) ?
                        CNT_W'(PAGE_CAPACITY) : CNT_W'(size_pages);
    assign cfg_used   = (32'(reserved_reg) < 32'(cfg_total)) ?
                        CNT_W'(reserved_reg) : cfg_total;

    always_comb
    begin
        state_next        = state_reg;
        sweep_next        = sweep_reg;
        scan_next         = scan_reg;
        fword_next        = fword_reg;
        fbit_next         = fbit_reg;
        used_count_next   = used_count_reg;
        page_total_next   = page_total_reg;
        mem_size_next     = mem_size_reg;
        reserved_next     = reserved_reg;
        done_next         = 1'b0;
        status_next       = status_reg;
        page_address_next = page_address_reg;
        wr_en             = 1'b0;
        wr_addr           = '0;
        wr_data           = '0;
        rd_en             = 1'b0;
        rd_addr           = '0;

        case (state_reg)
            ST_INIT:
            begin
                wr_en   = 1'b1;
                wr_addr = sweep_reg;
                wr_data = init_word;
                if (sweep_reg == SWEEP_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + WORD_AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == bpa_pkg::MODE_ALLOC)
                    begin
                        if (page_total_reg == '0)
                        begin
                            done_next         = 1'b1;
                            status_next       = bpa_pkg::STATUS_OOM;
                            page_address_next = '0;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            scan_next  = '0;
                            state_next = ST_SCAN;
                        end
                    end
                    else if (free_in_range)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = free_pidx[PIDX_W-1:BIT_W];
                        fword_next = free_pidx[PIDX_W-1:BIT_W];
                        fbit_next  = free_pidx[BIT_W-1:0];
                        state_next = ST_FREE_CHK;
                    end
                    else
                    begin
                        done_next         = 1'b1;
                        status_next       = bpa_pkg::STATUS_IGNORED;
                        page_address_next = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                // rd_data holds map word scan_reg
                if (zero_found)
                begin
                    wr_en             = 1'b1;
                    wr_addr           = scan_reg;
                    wr_data           = rd_data | zero_onehot;
                    used_count_next   = used_count_reg + CNT_W'(1);
                    done_next         = 1'b1;
                    status_next       = bpa_pkg::STATUS_ALLOC;
                    page_address_next = hit_ext[bpa_pkg::ADDR_W-1:0];
                    state_next        = ST_IDLE;
                end
                else if (scan_reg == last_word)
                begin
                    done_next         = 1'b1;
                    status_next       = bpa_pkg::STATUS_OOM;
                    page_address_next = '0;
                    state_next        = ST_IDLE;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = scan_reg + WORD_AW'(1);
                    scan_next = scan_reg + WORD_AW'(1);
                end
            end
            ST_FREE_CHK:
            begin
                if (rd_data[fbit_reg])
                begin
                    wr_en           = 1'b1;
                    wr_addr         = fword_reg;
                    wr_data         = rd_data & ~fbit_onehot;
                    used_count_next = used_count_reg - CNT_W'(1);
                    status_next     = bpa_pkg::STATUS_FREED;
                end
                else
                begin
                    status_next = bpa_pkg::STATUS_IGNORED;
                end
                done_next         = 1'b1;
                page_address_next = '0;
                state_next        = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr)
        begin
            case (cfg_index)
                bpa_pkg::CFG_MEM_SIZE:
                begin
                    mem_size_next   = cfg_data;
                    page_total_next = cfg_total;
                    used_count_next = cfg_used;
                    sweep_next      = '0;
                    state_next      = ST_INIT;
                end
                bpa_pkg::CFG_RESERVED:
                begin
                    reserved_next = cfg_data[bpa_pkg::RSV_W-1:0];
                end
                default:
                begin
                    reserved_next = reserved_reg;
                end
            endcase
        end

        free_pages_next = done_next ?
                          bpa_pkg::FREE_W'(page_total_next - used_count_next) :
                          free_pages_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            sweep_reg      <= '0;
            scan_reg       <= '0;
            used_count_reg <= CNT_W'(RST_USED);
            page_total_reg <= CNT_W'(RST_TOTAL);
            mem_size_reg   <= bpa_pkg::RST_MEM_SIZE_KB;
            reserved_reg   <= bpa_pkg::RST_RESERVED;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            scan_reg       <= scan_next;
            used_count_reg <= used_count_next;
            page_total_reg <= page_total_next;
            mem_size_reg   <= mem_size_next;
            reserved_reg   <= reserved_next;
            done_reg       <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        fword_reg        <= fword_next;
        fbit_reg         <= fbit_next;
        status_reg       <= status_next;
        page_address_reg <= page_address_next;
        free_pages_reg   <= free_pages_next;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign page_address = page_address_reg;
    assign free_pages   = free_pages_reg;

`include "bitmap_page_allocator_macros.svh"

    // used pages never exceed the page total
    `BPA_CHECK_NOW(a_used_le_total, clk, rst_n, 1'b1, used_count_reg <= page_total_reg)
    // every result strobe comes from an accepted item or work in progress
    `BPA_CHECK_NOW(a_done_has_item, clk, rst_n, done_reg, $past(accept || in_work))
    // an accepted item either finishes next cycle or keeps the block busy
    `BPA_CHECK_NEXT(a_accept_progress, clk, rst_n, accept && !cfg_wr, done_reg || busy)

endmodule
